// ===== hdl/yenc_pkg.sv =====
// yenc_pkg: shared types, constants and helper functions for the yEnc stream codec
// used by yenc_step, yenc_serial and yenc_stream_codec_core; no dependencies
package yenc_pkg;

    localparam int unsigned LINE_W = 13;

    localparam logic [7:0] ADD_OFFSET = 8'h2A;
    localparam logic [7:0] SUB_PLAIN  = 8'hD6;
    localparam logic [7:0] ESC_SHIFT  = 8'h40;
    localparam logic [7:0] ESC_CHAR   = 8'h3D;
    localparam logic [7:0] LINE_FEED  = 8'h0A;

    localparam logic [LINE_W-1:0] DEFAULT_LINE    = LINE_W'(128);
    localparam logic [LINE_W-1:0] MAX_LINE_LENGTH = LINE_W'(4096);

    typedef enum logic
    {
        REG_CODEC_MODE  = 1'b0,
        REG_LINE_LENGTH = 1'b1
    } reg_idx_t;

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } codec_mode_t;

    typedef struct packed
    {
        codec_mode_t       mode;
        logic [LINE_W-1:0] line_length;
    } cfg_t;

    // up to four output words caused by one input word
    typedef struct packed
    {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            stop;
        logic            str_end;
    } group_t;

    function automatic logic is_critical(input logic [7:0] v);
        logic r;
        r = (v == 8'h00) || (v == 8'h09) || (v == 8'h0A) || (v == 8'h0D) ||
            (v == 8'h2E) || (v == ESC_CHAR);
        return r;
    endfunction

    function automatic logic [LINE_W-1:0] eff_line(input logic [LINE_W-1:0] n);
        logic [LINE_W-1:0] r;
        r = n;
        if (n == '0)
        begin
            r = DEFAULT_LINE;
        end
        else if (n > MAX_LINE_LENGTH)
        begin
            r = MAX_LINE_LENGTH;
        end
        return r;
    endfunction

endpackage

// ===== hdl/yenc_step.sv =====
// yenc_step: per-word encode/decode logic and the string state registers
// (line position, escape flag, halt flag); depends on yenc_pkg
module yenc_step
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  yenc_pkg::cfg_t                 cfg,
    input  logic                           fire,
    input  logic [7:0]                     data_byte,
    input  logic                           last_in,
    output logic                           has_result,
    output yenc_pkg::group_t               group
);

    logic [yenc_pkg::LINE_W-1:0] line_pos_reg;
    logic [yenc_pkg::LINE_W-1:0] line_pos_next;
    logic                        escape_reg;
    logic                        escape_next;
    logic                        halted_reg;
    logic                        halted_next;

    logic [yenc_pkg::LINE_W-1:0] len;
    logic [yenc_pkg::LINE_W-1:0] pos1;
    logic [yenc_pkg::LINE_W-1:0] pos_mid;
    logic [yenc_pkg::LINE_W-1:0] pos_after;
    logic [7:0]                  enc_x;
    logic [7:0]                  enc_esc;
    logic                        enc_crit;
    logic                        lf_mid;
    logic                        lf_end;
    logic [7:0]                  dec_shift;

    always_comb
    begin
        len       = yenc_pkg::eff_line(cfg.line_length);
        enc_x     = data_byte + yenc_pkg::ADD_OFFSET;
        enc_esc   = enc_x + yenc_pkg::ESC_SHIFT;
        enc_crit  = yenc_pkg::is_critical(enc_x);
        pos1      = line_pos_reg + yenc_pkg::LINE_W'(1);
        lf_mid    = enc_crit && (pos1 >= len);
        pos_mid   = lf_mid ? yenc_pkg::LINE_W'(1) : (pos1 + yenc_pkg::LINE_W'(1));
        pos_after = enc_crit ? pos_mid : pos1;
        lf_end    = (pos_after >= len);
        dec_shift = escape_reg ? yenc_pkg::ESC_SHIFT : 8'h00;

        group         = '0;
        group.str_end = last_in;
        has_result    = 1'b0;
        line_pos_next = line_pos_reg;
        escape_next   = escape_reg;
        halted_next   = halted_reg;

        case (cfg.mode)
            yenc_pkg::MODE_ENCODE:
            begin
                has_result    = 1'b1;
                line_pos_next = lf_end ? '0 : pos_after;
                if (!enc_crit)
                begin
                    group.bytes[0] = enc_x;
                    group.bytes[1] = yenc_pkg::LINE_FEED;
                    group.last_idx = lf_end ? 2'd1 : 2'd0;
                end
                else if (lf_mid)
                begin
                    group.bytes[0] = yenc_pkg::ESC_CHAR;
                    group.bytes[1] = yenc_pkg::LINE_FEED;
                    group.bytes[2] = enc_esc;
                    group.bytes[3] = yenc_pkg::LINE_FEED;
                    group.last_idx = lf_end ? 2'd3 : 2'd2;
                end
                else
                begin
                    group.bytes[0] = yenc_pkg::ESC_CHAR;
                    group.bytes[1] = enc_esc;
                    group.bytes[2] = yenc_pkg::LINE_FEED;
                    group.last_idx = lf_end ? 2'd2 : 2'd1;
                end
            end
            yenc_pkg::MODE_DECODE:
            begin
                if (!halted_reg)
                begin
                    if (yenc_pkg::is_critical(data_byte))
                    begin
                        if (data_byte == yenc_pkg::ESC_CHAR)
                        begin
                            escape_next = 1'b1;
                        end
                    end
                    else if (escape_reg &&
                             !yenc_pkg::is_critical(data_byte - yenc_pkg::ESC_SHIFT))
                    begin
                        // invalid escape: flag once, drop the rest of the string
                        halted_next = 1'b1;
                        escape_next = 1'b0;
                        has_result  = 1'b1;
                        group.stop  = 1'b1;
                    end
                    else
                    begin
                        has_result     = 1'b1;
                        group.bytes[0] = data_byte + yenc_pkg::SUB_PLAIN - dec_shift;
                        escape_next    = 1'b0;
                    end
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase

        if (last_in)
        begin
            line_pos_next = '0;
            escape_next   = 1'b0;
            halted_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_reg <= '0;
            escape_reg   <= 1'b0;
            halted_reg   <= 1'b0;
        end
        else if (fire)
        begin
            line_pos_reg <= line_pos_next;
            escape_reg   <= escape_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

// ===== hdl/yenc_serial.sv =====
// yenc_serial: result register holding one word group, sent out one word per cycle
// while m_tready is high; depends on yenc_pkg
module yenc_serial
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  yenc_pkg::group_t group,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic [1:0]       m_tuser
);

    yenc_pkg::group_t grp_reg;
    logic             valid_reg;
    logic [1:0]       idx_reg;
    logic             at_last;

    assign at_last  = (idx_reg == grp_reg.last_idx);
    // room for a new group when empty, or once the last word of the current one leaves
    assign free     = !valid_reg || (m_tready && at_last);

    assign m_tvalid = valid_reg;
    assign m_tdata  = grp_reg.bytes[idx_reg];
    assign m_tlast  = at_last;
    assign m_tuser  = {grp_reg.str_end, grp_reg.stop};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && m_tready)
        begin
            if (at_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

// ===== hdl/yenc_stream_codec_core.sv =====
// yenc_stream_codec_core: top level of the yEnc byte-stream encoder/decoder
// depends on yenc_pkg, yenc_step and yenc_serial
//
// The block sends one output word per cycle while m_tready is high. An input
// word is taken when the result register is empty, or in the same cycle that
// the last word of the previous result group leaves. An encoded input word
// yields one to four words (character, optional escape and up to two line
// feeds), a decoded one a single word, and a decode input that yields nothing
// (skipped or halted) loads no group. String state clears after a word with
// s_tlast set. Configuration writes take effect at the next clock edge.
module yenc_stream_codec_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  yenc_pkg::reg_idx_t                cfg_addr,
    input  logic [yenc_pkg::LINE_W-1:0]       cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // last_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] out_byte
    output logic                              m_tlast,   // run_last
    output logic [1:0]                        m_tuser    // [0] decode_stop, [1] string_end
);

    yenc_pkg::cfg_t   cfg_reg;
    yenc_pkg::group_t group;
    logic             has_result;
    logic             fire;
    logic             free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= yenc_pkg::MODE_ENCODE;
            cfg_reg.line_length <= yenc_pkg::DEFAULT_LINE;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                yenc_pkg::REG_CODEC_MODE:
                begin
                    cfg_reg.mode <= yenc_pkg::codec_mode_t'(cfg_wdata[0]);
                end
                yenc_pkg::REG_LINE_LENGTH:
                begin
                    cfg_reg.line_length <= cfg_wdata;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign s_tready = free;
    assign fire     = s_tvalid && s_tready;

    yenc_step u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fire       (fire),
        .data_byte  (s_tdata),
        .last_in    (s_tlast),
        .has_result (has_result),
        .group      (group)
    );

    yenc_serial u_serial
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && has_result),
        .group    (group),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/yenc_checker.sv =====
// yenc_checker: port-level assertions for yenc_stream_codec_core, bound to the top
// depends on yenc_stream_codec_core only through its ports
module yenc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // stalled word is held
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

    // words of one group follow without a gap
    a_group_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a result group");

    // decode stop is a lone zero word
    a_stop_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == 8'h00) && m_tlast)
        else $error("decode stop word malformed");

    // string end marks every word of the group
    a_end_group: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast && m_tuser[1] |=> m_tuser[1])
        else $error("string end flag changed inside a group");

endmodule

bind yenc_stream_codec_core yenc_checker u_yenc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/yenc_codec_tb_pkg.sv =====
`timescale 1ns / 100ps
// yenc_codec_tb_pkg: word type, critical-byte test and predicting scoreboard for the
// yenc_stream_codec_core testbench; depends on yenc_pkg for types and constants
package yenc_codec_tb_pkg;

    import yenc_pkg::*;

    typedef struct packed
    {
        logic [7:0] data;
        logic       run_last;
        logic       stop;
        logic       str_end;
    } codec_word_t;

    function automatic bit critical_byte(input logic [7:0] v);
        return v inside {8'h00, 8'h09, LINE_FEED, 8'h0D, 8'h2E, ESC_CHAR};
    endfunction

    class yenc_codec_scoreboard;

        codec_mode_t       mode;
        logic [LINE_W-1:0] line_len;
        logic [LINE_W-1:0] line_pos;
        logic              esc_armed;
        logic              halted;
        codec_word_t       expected_words[$];
        int                mismatches;

        function new();
            mode       = MODE_ENCODE;
            line_len   = DEFAULT_LINE;
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            line_pos  = '0;
            esc_armed = 1'b0;
            halted    = 1'b0;
        endfunction

        function void set_reg(input reg_idx_t idx, input logic [LINE_W-1:0] val);
            if (idx == REG_CODEC_MODE)
            begin
                mode = codec_mode_t'(val[0]);
            end
            else
            begin
                line_len = val;
            end
        endfunction

        function logic [LINE_W-1:0] active_line_len();
            if (line_len == '0)
            begin
                return DEFAULT_LINE;
            end
            if (line_len > MAX_LINE_LENGTH)
            begin
                return MAX_LINE_LENGTH;
            end
            return line_len;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // works out the words caused by one accepted input byte
        function void predict_byte(input logic [7:0] b, input logic last);
            codec_word_t       grp[$];
            logic [7:0]        x;
            logic [7:0]        y;
            logic [LINE_W-1:0] lim;
            if (mode == MODE_ENCODE)
            begin
                lim = active_line_len();
                x   = b + ADD_OFFSET;
                line_pos++;
                if (critical_byte(x))
                begin
                    grp.push_back('{ESC_CHAR, 1'b0, 1'b0, last});
                    // line break can fall between the escape and its character
                    if (line_pos >= lim)
                    begin
                        line_pos = LINE_W'(1);
                        grp.push_back('{LINE_FEED, 1'b0, 1'b0, last});
                    end
                    else
                    begin
                        line_pos++;
                    end
                    y = x + ESC_SHIFT;
                    grp.push_back('{y, 1'b0, 1'b0, last});
                end
                else
                begin
                    grp.push_back('{x, 1'b0, 1'b0, last});
                end
                if (line_pos >= lim)
                begin
                    line_pos = '0;
                    grp.push_back('{LINE_FEED, 1'b0, 1'b0, last});
                end
            end
            else if (!halted)
            begin
                y = b - ESC_SHIFT;
                if (critical_byte(b))
                begin
                    if (b == ESC_CHAR)
                    begin
                        esc_armed = 1'b1;
                    end
                end
                else if (esc_armed && !critical_byte(y))
                begin
                    halted    = 1'b1;
                    esc_armed = 1'b0;
                    grp.push_back('{8'h00, 1'b0, 1'b1, last});
                end
                else
                begin
                    x = b - ADD_OFFSET - (esc_armed ? ESC_SHIFT : 8'h00);
                    grp.push_back('{x, 1'b0, 1'b0, last});
                    esc_armed = 1'b0;
                end
            end
            if (grp.size() > 0)
            begin
                grp[grp.size() - 1].run_last = 1'b1;
            end
            foreach (grp[i])
            begin
                expected_words.push_back(grp[i]);
            end
            if (last)
            begin
                clear_string();
            end
        endfunction

        function void flag(input string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        function void check_word(input logic [7:0] data, input logic run_last,
                                 input logic [1:0] user);
            codec_word_t want;
            if (expected_words.size() == 0)
            begin
                flag($sformatf("unexpected word: out_byte %02h run_last %0b user %02b",
                               data, run_last, user));
                return;
            end
            want = expected_words.pop_front();
            if (want.data !== data || want.run_last !== run_last ||
                want.stop !== user[0] || want.str_end !== user[1])
            begin
                flag($sformatf({"word mismatch (exp/got): out_byte %02h/%02h ",
                                "run_last %0b/%0b decode_stop %0b/%0b string_end %0b/%0b"},
                               want.data, data, want.run_last, run_last,
                               want.stop, user[0], want.str_end, user[1]));
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_yenc_stream_codec_core.sv =====
`timescale 1ns / 100ps
// tb_yenc_stream_codec_core: drives yenc_stream_codec_core with directed and random
// encode/decode strings under random stalls; depends on yenc_pkg and yenc_codec_tb_pkg
module tb_yenc_stream_codec_core;

    import yenc_pkg::*;
    import yenc_codec_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 9;
    localparam int PHASE_BYTES   = 38;

    logic              clk;
    logic              rst_n;
    logic              cfg_wen;
    reg_idx_t          cfg_addr;
    logic [LINE_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;
    logic              m_tlast;
    logic [1:0]        m_tuser;

    yenc_codec_scoreboard sb;
    bit                   tx_steady;
    bit                   rx_steady;
    int                   cycles = 0;
    int                   rx_hold;

    yenc_stream_codec_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_word(m_tdata, m_tlast, m_tuser);
        end
    end

    // receiver back-pressure
    initial
    begin
        m_tready = 1'b0;
        rx_hold  = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 5) == 0)
                begin
                    rx_hold = gap_cycles();
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 2) == 0)
        begin
            gap = gap_cycles();
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.predict_byte(b, last);
        @(negedge clk);
    endtask

    // hold off input until every expected word is out, then let the block go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_regs(input codec_mode_t m, input logic [LINE_W-1:0] len);
        cfg_wen   <= 1'b1;
        cfg_addr  <= REG_CODEC_MODE;
        cfg_wdata <= LINE_W'(m);
        sb.set_reg(REG_CODEC_MODE, LINE_W'(m));
        @(negedge clk);
        cfg_addr  <= REG_LINE_LENGTH;
        cfg_wdata <= len;
        sb.set_reg(REG_LINE_LENGTH, len);
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic run_directed();
        // raw values that land on each critical byte after the offset
        write_regs(MODE_ENCODE, LINE_W'(3));
        send_byte(8'hD6, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hE3, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h13, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();
        // one-character lines: escaped byte gives four words
        write_regs(MODE_ENCODE, LINE_W'(1));
        send_byte(8'h13, 1'b0);
        send_byte(8'h7F, 1'b1);
        settle();
        write_regs(MODE_DECODE, LINE_W'(1));
        send_byte(ESC_CHAR, 1'b0);
        send_byte(8'h40, 1'b0);
        // critical byte while escaped keeps the escape armed
        send_byte(ESC_CHAR, 1'b0);
        send_byte(LINE_FEED, 1'b0);
        send_byte(8'h7D, 1'b0);
        send_byte(8'h2A, 1'b0);
        send_byte(8'hFF, 1'b0);
        // skipped byte carrying the end mark
        send_byte(8'h0D, 1'b1);
        // invalid escape, then halted bytes up to the end of the string
        send_byte(ESC_CHAR, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h60, 1'b1);
    endtask

    task automatic run_random_phase(input int idx);
        logic [7:0]        hot[6];
        logic [7:0]        skip_set[5];
        logic [7:0]        seq[$];
        logic [7:0]        raw;
        logic [7:0]        x;
        logic [LINE_W-1:0] len;
        codec_mode_t       m;
        int                r;
        hot      = '{8'hD6, 8'hDF, 8'hE0, 8'hE3, 8'h04, 8'h13};
        skip_set = '{8'h00, 8'h09, LINE_FEED, 8'h0D, 8'h2E};
        settle();
        if (idx < 6)
        begin
            m = (idx % 2 == 0) ? MODE_ENCODE : MODE_DECODE;
        end
        else
        begin
            m = ($urandom_range(0, 1) == 0) ? MODE_ENCODE : MODE_DECODE;
        end
        case (idx)
            0: len = '0;
            2: len = '1;
            4: len = MAX_LINE_LENGTH;
            default:
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                begin
                    len = LINE_W'($urandom_range(4097, 8191));
                end
                else if (r == 1)
                begin
                    len = DEFAULT_LINE;
                end
                else
                begin
                    len = LINE_W'($urandom_range(1, 12));
                end
            end
        endcase
        write_regs(m, len);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);

        while (seq.size() < PHASE_BYTES)
        begin
            raw = ($urandom_range(0, 9) < 3) ? hot[$urandom_range(0, 5)] : 8'($urandom);
            if (m == MODE_ENCODE)
            begin
                seq.push_back(raw);
            end
            else
            begin
                // mostly well-formed encoded text, some line breaks and noise
                r = $urandom_range(0, 99);
                if (r < 62)
                begin
                    x = raw + ADD_OFFSET;
                    if (critical_byte(x))
                    begin
                        seq.push_back(ESC_CHAR);
                        seq.push_back(x + ESC_SHIFT);
                    end
                    else
                    begin
                        seq.push_back(x);
                    end
                end
                else if (r < 72)
                begin
                    seq.push_back(skip_set[$urandom_range(0, 4)]);
                end
                else if (r < 80)
                begin
                    seq.push_back(ESC_CHAR);
                    seq.push_back(8'($urandom));
                end
                else
                begin
                    seq.push_back(8'($urandom));
                end
            end
        end

        foreach (seq[i])
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                settle();
            end
            send_byte(seq[i], $urandom_range(0, 23) == 0);
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_addr  = REG_CODEC_MODE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            run_random_phase(p);
        end
        settle();

        if (sb.mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
